// ===== rtl/lesps_pkg.sv =====
`default_nettype none

package lesps_pkg;

  localparam int unsigned DefaultLengthBits = 16;
  localparam int unsigned DefaultQueueDepth = 4;
  localparam int unsigned ByteW             = 8;
  localparam int unsigned PrefixW           = 16;
  localparam int unsigned CfgW              = 13;
  localparam int unsigned ChunkLenW         = 13;
  localparam int unsigned IndexW            = 8;

  localparam logic [CfgW-1:0]   MaxChunkReset = 13'd179;
  localparam logic [IndexW-1:0] LastIndex     = 8'hFF;

  localparam logic ResChunk = 1'b0;
  localparam logic ResError = 1'b1;

  typedef enum logic [1:0] {
    CmdNone,
    CmdTrail,
    CmdPlace
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PhLenLo,
    PhLenHi,
    PhBody
  } phase_e;

  typedef struct packed {
    logic empty;
    logic full;
    logic room_two;
  } q_status_t;

  // Entry end positions need one bit above the wider of position and prefix.
  function automatic int unsigned fin_width(int unsigned lb);
    return ((lb > PrefixW) ? lb : PrefixW) + 1;
  endfunction

  function automatic int unsigned cmd_width(int unsigned lb);
    return 3 + 2 * lb + fin_width(lb);
  endfunction

  function automatic int unsigned res_width(int unsigned lb);
    return lb + ChunkLenW + IndexW + 3;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/log_entry_packet_segmenter.sv =====
// Path: a byte accepted enters the command queue; the back packer then moves
//   its results into the result queue, from which they reach the result ports.
// Throughput: one byte per cycle while full is low; results leave one word per
//   cycle, so a byte that closes a chunk and ends the query yields two words.
// Reset: asynchronous, active low; clears both queues, all parser and packer
//   state, and loads the chunk size register with 179.
`default_nettype none

module log_entry_packet_segmenter #(
  parameter int unsigned LengthBits = lesps_pkg::DefaultLengthBits,
  parameter int unsigned QueueDepth = lesps_pkg::DefaultQueueDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte side
  input  logic                            push,
  output logic                            full,
  input  logic [lesps_pkg::ByteW-1:0]     data_byte_i,
  input  logic [LengthBits-1:0]           total_length_i,
  input  logic                            start_of_query_i,
  // chunk size register
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lesps_pkg::CfgW-1:0]      cfg_data_i,
  // result side
  output logic                            empty,
  input  logic                            pop,
  output logic                            result_kind_o,
  output logic [LengthBits-1:0]           chunk_offset_o,
  output logic [lesps_pkg::ChunkLenW-1:0] chunk_length_o,
  output logic [lesps_pkg::IndexW-1:0]    packet_index_o,
  output logic                            query_done_o,
  output logic                            last_of_run_o
);
  import lesps_pkg::*;

  localparam int unsigned CmdW = cmd_width(LengthBits);
  localparam int unsigned ResW = res_width(LengthBits);

  typedef struct packed {
    logic                  kind;
    logic [LengthBits-1:0] offset;
    logic [ChunkLenW-1:0]  length;
    logic [IndexW-1:0]     index;
    logic                  done;
    logic                  last;
  } res_t;

  logic [CfgW-1:0] max_chunk_q;
  logic            accept;
  logic            cmd_valid, cmd_pop;
  logic [CmdW-1:0] cmd_wr, cmd_rd;
  q_status_t       cmd_status, res_status;
  logic            res_wr0, res_wr1, res_rd;
  logic [ResW-1:0] res0, res1, res_rd_data;
  res_t            head;

  // The register must be written only while the block is idle; the block does not enforce it, so take it at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_q <= MaxChunkReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_chunk_q <= cfg_data_i;
    end
  end

  // Hold off bytes only while the command queue has no free slot; the front
  // never waits on the result side directly.
  assign full   = cmd_status.full;
  assign accept = push && !full;

  // Front: track position and length prefix, turn bytes into commands.
  lesps_front #(
    .LengthBits(LengthBits)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .total_length_i  (total_length_i),
    .start_of_query_i(start_of_query_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd_wr)
  );

  lesps_queue #(
    .Width(CmdW),
    .Depth(QueueDepth)
  ) u_cmd_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr0_i     (cmd_valid),
    .wr_data0_i(cmd_wr),
    .wr1_i     (1'b0),
    .wr_data1_i('0),
    .rd_i      (cmd_pop),
    .rd_data_o (cmd_rd),
    .status_o  (cmd_status)
  );

  // Back: pack entries into chunks; advance only while two result slots are
  // free, since one command may emit a flushed chunk and a final word.
  lesps_back #(
    .LengthBits(LengthBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_chunk_i (max_chunk_q),
    .cmd_status_i(cmd_status),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .res_status_i(res_status),
    .res_wr0_o   (res_wr0),
    .res0_o      (res0),
    .res_wr1_o   (res_wr1),
    .res1_o      (res1)
  );

  lesps_queue #(
    .Width(ResW),
    .Depth(QueueDepth)
  ) u_res_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr0_i     (res_wr0),
    .wr_data0_i(res0),
    .wr1_i     (res_wr1),
    .wr_data1_i(res1),
    .rd_i      (res_rd),
    .rd_data_o (res_rd_data),
    .status_o  (res_status)
  );

  // The oldest result word sits at the queue head while empty is low.
  assign empty  = res_status.empty;
  assign res_rd = pop && !empty;
  assign head   = res_t'(res_rd_data);

  assign result_kind_o  = head.kind;
  assign chunk_offset_o = head.offset;
  assign chunk_length_o = head.length;
  assign packet_index_o = head.index;
  assign query_done_o   = head.done;
  assign last_of_run_o  = head.last;

endmodule

`default_nettype wire

// ===== rtl/lesps_queue.sv =====
`default_nettype none

module lesps_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = lesps_pkg::DefaultQueueDepth,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr0_i,
  input  logic [Width-1:0]     wr_data0_i,
  input  logic                 wr1_i,
  input  logic [Width-1:0]     wr_data1_i,
  input  logic                 rd_i,
  output logic [Width-1:0]     rd_data_o,
  output lesps_pkg::q_status_t status_o
);
  import lesps_pkg::*;

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wr_addr1;
  logic [AddrW:0]   count_q, count_d;

  always_comb begin
    wr_addr1 = wptr_q + AddrW'(wr0_i);
    wptr_d   = wptr_q + AddrW'(wr0_i) + AddrW'(wr1_i);
    rptr_d   = rptr_q + AddrW'(rd_i);
    count_d  = count_q + (AddrW+1)'(wr0_i) + (AddrW+1)'(wr1_i) - (AddrW+1)'(rd_i);
    status_o.empty    = (count_q == '0);
    status_o.full     = (count_q == (AddrW+1)'(Depth));
    status_o.room_two = (count_q <= (AddrW+1)'(Depth - 2));
    rd_data_o = mem_q[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr0_i) begin
      mem_q[wptr_q] <= wr_data0_i;
    end
    if (wr1_i) begin
      mem_q[wr_addr1] <= wr_data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AddrW+1)'(Depth))
    else $error("queue count above depth");

  a_pair_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr1_i |-> (wr0_i && status_o.room_two))
    else $error("second write without room or first write");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !status_o.empty)
    else $error("read from empty queue");

endmodule

`default_nettype wire

// ===== rtl/lesps_front.sv =====
`default_nettype none

module lesps_front #(
  parameter int unsigned LengthBits = lesps_pkg::DefaultLengthBits,
  localparam int unsigned FinW = lesps_pkg::fin_width(LengthBits),
  localparam int unsigned CmdW = lesps_pkg::cmd_width(LengthBits)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [lesps_pkg::ByteW-1:0] data_byte_i,
  input  logic [LengthBits-1:0]       total_length_i,
  input  logic                        start_of_query_i,
  output logic                        cmd_valid_o,
  output logic [CmdW-1:0]             cmd_o
);
  import lesps_pkg::*;

  typedef struct packed {
    logic                  restart;
    cmd_kind_e             kind;
    logic [LengthBits-1:0] start;
    logic [FinW-1:0]       fin;
    logic [LengthBits-1:0] total;
  } cmd_t;

  logic [LengthBits-1:0] pos_q, pos_d, p;
  phase_e                phase_q, phase_d, phase_c;
  logic [ByteW-1:0]      low_q, low_d, low_c;
  logic [FinW-1:0]       fin_q, fin_d, fin_c, fin_new, p_next;
  logic                  in_range;
  cmd_t                  cmd;

  always_comb begin
    p       = start_of_query_i ? '0 : pos_q;
    phase_c = start_of_query_i ? PhLenLo : phase_q;
    low_c   = start_of_query_i ? '0 : low_q;
    fin_c   = start_of_query_i ? '0 : fin_q;
    p_next  = FinW'(p) + FinW'(1);
    fin_new = p_next + FinW'({data_byte_i, low_c});
    in_range = (p < total_length_i);

    pos_d   = pos_q;
    phase_d = phase_q;
    low_d   = low_q;
    fin_d   = fin_q;

    cmd.restart = start_of_query_i;
    cmd.kind    = CmdNone;
    cmd.start   = p;
    cmd.fin     = fin_new;
    cmd.total   = total_length_i;

    if (accept_i) begin
      pos_d   = (&p) ? p : p + LengthBits'(1);
      phase_d = phase_c;
      low_d   = low_c;
      fin_d   = fin_c;
      if (in_range) begin
        unique case (phase_c)
          PhLenLo: begin
            // a lone byte where a prefix should start closes the query
            if (p_next == FinW'(total_length_i)) begin
              cmd.kind = CmdTrail;
            end else begin
              low_d   = data_byte_i;
              phase_d = PhLenHi;
            end
          end
          PhLenHi: begin
            fin_d     = fin_new;
            phase_d   = ({data_byte_i, low_c} == '0) ? PhLenLo : PhBody;
            cmd.kind  = CmdPlace;
            cmd.start = p - LengthBits'(1);
          end
          PhBody: begin
            if (p_next >= fin_c) begin
              phase_d = PhLenLo;
            end
          end
          default: phase_d = PhLenLo;
        endcase
      end
    end

    cmd_valid_o = accept_i && (start_of_query_i || (cmd.kind != CmdNone));
    cmd_o       = cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PhLenLo;
      low_q   <= '0;
      fin_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      low_q   <= low_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lesps_back.sv =====
`default_nettype none

module lesps_back #(
  parameter int unsigned LengthBits = lesps_pkg::DefaultLengthBits,
  localparam int unsigned FinW = lesps_pkg::fin_width(LengthBits),
  localparam int unsigned CmdW = lesps_pkg::cmd_width(LengthBits),
  localparam int unsigned ResW = lesps_pkg::res_width(LengthBits)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lesps_pkg::CfgW-1:0] max_chunk_i,
  input  lesps_pkg::q_status_t       cmd_status_i,
  input  logic [CmdW-1:0]            cmd_i,
  output logic                       cmd_pop_o,
  input  lesps_pkg::q_status_t       res_status_i,
  output logic                       res_wr0_o,
  output logic [ResW-1:0]            res0_o,
  output logic                       res_wr1_o,
  output logic [ResW-1:0]            res1_o
);
  import lesps_pkg::*;

  typedef struct packed {
    logic                  restart;
    cmd_kind_e             kind;
    logic [LengthBits-1:0] start;
    logic [FinW-1:0]       fin;
    logic [LengthBits-1:0] total;
  } cmd_t;

  typedef struct packed {
    logic                  kind;
    logic [LengthBits-1:0] offset;
    logic [ChunkLenW-1:0]  length;
    logic [IndexW-1:0]     index;
    logic                  done;
    logic                  last;
  } res_t;

  cmd_t                  cmd;
  res_t                  res_a, res_b;
  logic [LengthBits-1:0] cb_q, cb_d, cb_c, ce_q, ce_d, ce_c, b_begin;
  logic [IndexW-1:0]     ps_q, ps_d, ps_c;
  logic                  ab_q, ab_d, ab_c;
  logic [FinW-1:0]       tot_f, st_f, max_f, span;
  logic                  take, single_pkt, fits1, fits2, too_big, has_open, split;
  logic                  a_valid, b_valid, b_error;

  always_comb begin
    cmd  = cmd_t'(cmd_i);
    take = !cmd_status_i.empty && res_status_i.room_two;

    cb_c = cmd.restart ? '0 : cb_q;
    ce_c = cmd.restart ? '0 : ce_q;
    ps_c = cmd.restart ? '0 : ps_q;
    ab_c = cmd.restart ? 1'b0 : ab_q;

    tot_f = FinW'(cmd.total);
    st_f  = FinW'(cmd.start);
    max_f = FinW'(max_chunk_i);
    span  = (cmd.kind == CmdTrail) ? (tot_f - st_f) : (cmd.fin - st_f);

    single_pkt = (tot_f <= max_f);
    fits1      = (cmd.fin <= FinW'(cb_c) + max_f) && (cmd.fin <= tot_f);
    fits2      = (cmd.fin <= st_f + max_f) && (cmd.fin <= tot_f);
    too_big    = (span > max_f);
    has_open   = (ce_c > cb_c);
    split      = (cmd.kind == CmdTrail) || ((cmd.kind == CmdPlace) && !fits1);

    // flush the open chunk before a trailing byte or an entry that does not fit it
    a_valid = !ab_c && split && has_open;
    b_valid = !ab_c && ((cmd.kind == CmdTrail) ||
              ((cmd.kind == CmdPlace) &&
               (fits1 ? (cmd.fin == tot_f) : (!fits2 || (cmd.fin == tot_f)))));
    b_error = split && too_big;
    b_begin = split ? cmd.start : cb_c;

    res_a.kind   = ResChunk;
    res_a.offset = cb_c;
    res_a.length = ChunkLenW'(ce_c - cb_c);
    res_a.index  = single_pkt ? '0 : ps_c + IndexW'(1);
    res_a.done   = 1'b0;
    res_a.last   = !b_valid;

    res_b.kind   = b_error ? ResError : ResChunk;
    res_b.offset = b_begin;
    res_b.length = b_error ? '0 : ChunkLenW'(cmd.total - b_begin);
    res_b.index  = (b_error || single_pkt) ? '0 : LastIndex;
    res_b.done   = 1'b1;
    res_b.last   = 1'b1;

    cb_d = cb_q;
    ce_d = ce_q;
    ps_d = ps_q;
    ab_d = ab_q;
    if (take) begin
      cb_d = cb_c;
      ce_d = ce_c;
      ps_d = ps_c + IndexW'(a_valid) + IndexW'(b_valid && !b_error);
      ab_d = ab_c || b_valid;
      if (!ab_c && (cmd.kind != CmdNone)) begin
        if (split) begin
          cb_d = cmd.start;
          ce_d = cmd.start;
        end
        if ((cmd.kind == CmdPlace) && (fits1 || fits2)) begin
          ce_d = LengthBits'(cmd.fin);
        end
      end
    end

    cmd_pop_o = take;
    res_wr0_o = take && (a_valid || b_valid);
    res0_o    = a_valid ? res_a : res_b;
    res_wr1_o = take && a_valid && b_valid;
    res1_o    = res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q <= '0;
      ce_q <= '0;
      ps_q <= '0;
      ab_q <= 1'b0;
    end else begin
      cb_q <= cb_d;
      ce_q <= ce_d;
      ps_q <= ps_d;
      ab_q <= ab_d;
    end
  end

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr1_o |-> (res_a.kind == ResChunk && !res_a.done && !res_a.last))
    else $error("result pair does not open with a plain chunk");

  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && b_valid) |=> ab_q)
    else $error("query not closed after final result");

endmodule

`default_nettype wire

// ===== test/chunk_tracker_pkg.sv =====
`timescale 1ns / 1ps

package chunk_tracker_pkg;
  import lesps_pkg::*;

  localparam int unsigned PosW   = DefaultLengthBits;
  localparam int unsigned EntryW = PosW + 1;
  localparam int unsigned PosMax = (1 << PosW) - 1;

  typedef struct packed {
    logic                 kind;
    logic [PosW-1:0]      offset;
    logic [ChunkLenW-1:0] length;
    logic [IndexW-1:0]    index;
    logic                 done;
    logic                 last;
  } chunk_word_t;

  class chunk_tracker;
    logic [CfgW-1:0]   chunk_limit;
    logic [PosW-1:0]   next_pos;
    logic [PosW-1:0]   chunk_start;
    logic [PosW-1:0]   placed_end;
    logic [EntryW-1:0] entry_end;
    phase_e            phase;
    logic [ByteW-1:0]  len_lo;
    logic [IndexW-1:0] sent_count;
    logic              halted;
    chunk_word_t       fresh[$];
    chunk_word_t       pending[$];
    int unsigned       failures;

    function new();
      chunk_limit = MaxChunkReset;
      failures    = 0;
      restart();
    endfunction

    function void restart();
      next_pos    = '0;
      chunk_start = '0;
      placed_end  = '0;
      entry_end   = '0;
      phase       = PhLenLo;
      len_lo      = '0;
      sent_count  = '0;
      halted      = 1'b0;
    endfunction

    function void set_limit(logic [CfgW-1:0] value);
      chunk_limit = value;
    endfunction

    // Close the chunk [chunk_start, stop) and open the next one at stop.
    function void emit_chunk(int unsigned stop, int unsigned total);
      chunk_word_t w;
      bit          ends;
      ends     = (stop >= total);
      w.kind   = ResChunk;
      w.offset = chunk_start;
      w.length = ChunkLenW'(stop - chunk_start);
      if (total <= chunk_limit) begin
        w.index = '0;
      end else if (ends) begin
        w.index = LastIndex;
      end else begin
        w.index = sent_count + 1'b1;
      end
      w.done      = ends;
      w.last      = 1'b0;
      fresh.push_back(w);
      sent_count  = sent_count + 1'b1;
      chunk_start = PosW'(stop);
      placed_end  = PosW'(stop);
      if (ends) begin
        halted = 1'b1;
      end
    endfunction

    function void emit_error(int unsigned at);
      chunk_word_t w;
      w.kind   = ResError;
      w.offset = PosW'(at);
      w.length = '0;
      w.index  = '0;
      w.done   = 1'b1;
      w.last   = 1'b0;
      fresh.push_back(w);
      halted = 1'b1;
    endfunction

    function bit fits(int unsigned fin, int unsigned total);
      int unsigned room_end;
      room_end = chunk_start + chunk_limit;
      return (fin <= room_end) && (fin <= total);
    endfunction

    function void note_byte(logic [ByteW-1:0] data, logic [PosW-1:0] total, logic sos);
      chunk_word_t w;
      int unsigned p;
      int unsigned fin;
      int unsigned start;
      int unsigned tot;
      bit          placed;
      fresh.delete();
      if (sos) begin
        restart();
      end
      p   = next_pos;
      tot = total;
      if (next_pos != PosMax) begin
        next_pos = next_pos + 1'b1;
      end
      if (!halted && p < tot) begin
        case (phase)
          PhLenLo: begin
            if (p + 1 == tot) begin
              // lone trailing byte where a prefix should start
              if (placed_end > chunk_start) begin
                emit_chunk(placed_end, tot);
              end
              chunk_start = PosW'(p);
              placed_end  = PosW'(p);
              if (tot - p > chunk_limit) begin
                emit_error(p);
              end else begin
                emit_chunk(tot, tot);
              end
            end else begin
              len_lo = data;
              phase  = PhLenHi;
            end
          end
          PhLenHi: begin
            fin       = p + 1 + {data, len_lo};
            entry_end = fin[EntryW-1:0];
            phase     = (fin == p + 1) ? PhLenLo : PhBody;
            start     = p - 1;
            placed    = fits(fin, tot);
            if (!placed) begin
              if (placed_end > chunk_start) begin
                emit_chunk(placed_end, tot);
              end
              chunk_start = PosW'(start);
              placed_end  = PosW'(start);
              placed      = fits(fin, tot);
              if (!placed) begin
                if (fin - start > chunk_limit) begin
                  emit_error(start);
                end else begin
                  emit_chunk(tot, tot);
                end
              end
            end
            if (placed) begin
              placed_end = PosW'(fin);
              if (fin == tot) begin
                emit_chunk(tot, tot);
              end
            end
          end
          default: begin
            if (p + 1 >= entry_end) begin
              phase = PhLenLo;
            end
          end
        endcase
      end
      for (int i = 0; i < fresh.size(); i++) begin
        w      = fresh[i];
        w.last = (i == fresh.size() - 1);
        pending.push_back(w);
      end
    endfunction

    function void check_result(chunk_word_t got);
      chunk_word_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result word: kind=%0d off=%0d len=%0d idx=%0d done=%0d last=%0d",
                   got.kind, got.offset, got.length, got.index, got.done, got.last);
        end
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.offset !== want.offset ||
          got.length !== want.length || got.index !== want.index ||
          got.done !== want.done || got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("result word mismatch: expected kind=%0d off=%0d len=%0d idx=%0d done=%0d last=%0d",
                   want.kind, want.offset, want.length, want.index, want.done, want.last);
          $display("                      got      kind=%0d off=%0d len=%0d idx=%0d done=%0d last=%0d",
                   got.kind, got.offset, got.length, got.index, got.done, got.last);
        end
      end
    endfunction
  endclass

endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lesps_pkg::*;
  import chunk_tracker_pkg::*;

  // Hard stop well above the slowest legal run: every byte paying the
  // longest gap and two result words behind the longest pop stall.
  localparam int unsigned CycleLimit = 1500000;
  // Cycles to let the pipeline drain after the last expected word.
  localparam int unsigned DrainCycles = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 push = 1'b0;
  logic                 full;
  logic [ByteW-1:0]     data_byte = '0;
  logic [PosW-1:0]      total_length = '0;
  logic                 start_of_query = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgW-1:0]      cfg_data = '0;

  logic                 empty;
  logic                 pop = 1'b0;
  logic                 result_kind;
  logic [PosW-1:0]      chunk_offset;
  logic [ChunkLenW-1:0] chunk_length;
  logic [IndexW-1:0]    packet_index;
  logic                 query_done;
  logic                 last_of_run;

  chunk_tracker tracker;
  chunk_word_t  result_word;
  bit           no_idle = 1'b0;
  int unsigned  cycle_count = 0;
  int unsigned  sent_bytes = 0;

  log_entry_packet_segmenter uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte),
    .total_length_i   (total_length),
    .start_of_query_i (start_of_query),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .empty            (empty),
    .pop              (pop),
    .result_kind_o    (result_kind),
    .chunk_offset_o   (chunk_offset),
    .chunk_length_o   (chunk_length),
    .packet_index_o   (packet_index),
    .query_done_o     (query_done),
    .last_of_run_o    (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back-to-back, some short gaps, a few long ones; none at all while
  // no_idle is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Entry length: mostly small, some spread across the chunk size, some right
  // at the fit edge or one past it, and a few fully random 16-bit lengths.
  function automatic int unsigned pick_entry_len(int unsigned limit);
    int unsigned r;
    int unsigned room;
    r    = $urandom_range(0, 99);
    room = (limit > 2) ? limit - 2 : 0;
    if (r < 65) return $urandom_range(0, (room < 40) ? room : 40);
    if (r < 80) return $urandom_range(0, room);
    if (r < 88) return room;
    if (r < 92) return room + 1;
    return $urandom_range(0, 65535);
  endfunction

  // Sample both handshakes at the rising edge: check the result word first,
  // then note the accepted byte.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        result_word.kind   = result_kind;
        result_word.offset = chunk_offset;
        result_word.length = chunk_length;
        result_word.index  = packet_index;
        result_word.done   = query_done;
        result_word.last   = last_of_run;
        tracker.check_result(result_word);
      end
      if (push && !full) begin
        tracker.note_byte(data_byte, total_length, start_of_query);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: alternate random stalls with runs of pops.
  initial begin
    int unsigned stall;
    int unsigned burst;
    forever begin
      stall = pick_gap();
      burst = $urandom_range(1, 16);
      repeat (stall) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      repeat (burst) begin
        @(negedge clk);
        pop <= 1'b1;
      end
    end
  end

  // Present one byte after a random gap and hold it until accepted. Leave
  // push high; the next call or settle() decides what happens at the next
  // falling edge.
  task automatic send_byte(logic [ByteW-1:0] b, logic [PosW-1:0] total, logic sos);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push           <= 1'b1;
    data_byte      <= b;
    total_length   <= total;
    start_of_query <= sos;
    do @(posedge clk); while (full);
    sent_bytes++;
  endtask

  // Drop push, wait for every expected word, then let the pipeline drain.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_chunk_limit(logic [CfgW-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_limit(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    // Bytes before any start: a query that began at reset. One entry of two
    // bytes, then an empty entry that lands exactly on the data end.
    send_byte(8'h02, 16'd6, 1'b0);
    send_byte(8'h00, 16'd6, 1'b0);
    send_byte(8'hAA, 16'd6, 1'b0);
    send_byte(8'hBB, 16'd6, 1'b0);
    send_byte(8'h00, 16'd6, 1'b0);
    send_byte(8'h00, 16'd6, 1'b0);
    // Past the end of a finished query: ignore.
    send_byte(8'hFF, 16'd6, 1'b0);
    // Single-byte query: trailing fragment of length one.
    send_byte(8'h00, 16'd1, 1'b1);
    // Zero-length query: no results.
    send_byte(8'h55, 16'd0, 1'b1);
    send_byte(8'h55, 16'd0, 1'b0);
    // Largest total with the largest entry length: too large for any chunk.
    send_byte(8'hFF, 16'hFFFF, 1'b1);
    send_byte(8'hFF, 16'hFFFF, 1'b0);
    // Entry running past the data end: clamp to a final chunk.
    send_byte(8'h14, 16'd10, 1'b1);
    send_byte(8'h00, 16'd10, 1'b0);
    send_byte(8'h33, 16'd10, 1'b0);

    // Tiny chunks: split query with running indexes, then a trailing byte
    // that closes one chunk and opens the last one in the same cycle.
    write_chunk_limit(13'd4);
    send_byte(8'h01, 16'd9, 1'b1);
    send_byte(8'h00, 16'd9, 1'b0);
    send_byte(8'h5A, 16'd9, 1'b0);
    send_byte(8'h00, 16'd9, 1'b0);
    send_byte(8'h00, 16'd9, 1'b0);
    send_byte(8'h01, 16'd9, 1'b0);
    send_byte(8'h00, 16'd9, 1'b0);
    send_byte(8'hA5, 16'd9, 1'b0);
    send_byte(8'h80, 16'd9, 1'b0);
  endtask

  // One query of well-formed entries with random content, sprinkled with
  // noise: corrupted bytes, a one-byte length change, a restart midway,
  // overrun past the end, early cut-off, and an occasional missing start.
  task automatic send_query();
    int unsigned     total;
    int unsigned     count;
    int unsigned     body_left;
    int unsigned     entry_len;
    int unsigned     r;
    phase_e          stage;
    logic [ByteW-1:0] b;
    logic [PosW-1:0] tl;
    logic            sos;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      total = $urandom_range(1, 80);
    end else if (r < 90) begin
      total = $urandom_range(81, 700);
    end else if (r < 95) begin
      total = $urandom_range(1, 3);
    end else begin
      total = $urandom_range(701, 65535);
    end
    // Abandon huge queries after a short prefix.
    count = (total > 700) ? $urandom_range(20, 100) : total;
    if ($urandom_range(0, 9) == 0) begin
      count = count + $urandom_range(1, 4);
    end else if ($urandom_range(0, 19) == 0 && count > 1) begin
      count = $urandom_range(1, count - 1);
    end
    stage     = PhLenLo;
    body_left = 0;
    entry_len = 0;
    for (int unsigned sent = 0; sent < count; sent++) begin
      case (stage)
        PhLenLo: begin
          entry_len = pick_entry_len(tracker.chunk_limit);
          b         = entry_len[7:0];
          stage     = PhLenHi;
        end
        PhLenHi: begin
          b         = entry_len[15:8];
          body_left = entry_len;
          stage     = (entry_len == 0) ? PhLenLo : PhBody;
        end
        default: begin
          b = ByteW'($urandom_range(0, 255));
          body_left--;
          if (body_left == 0) begin
            stage = PhLenLo;
          end
        end
      endcase
      tl  = PosW'(total);
      sos = (sent == 0) ? ($urandom_range(0, 31) != 0) : 1'b0;
      r   = $urandom_range(0, 99);
      if (r == 0) begin
        b = ByteW'($urandom_range(0, 255));
      end else if (r == 1) begin
        tl = PosW'($urandom_range(0, 65535));
      end else if (r == 2) begin
        sos = 1'b1;
      end
      send_byte(b, tl, sos);
    end
  endtask

  // Count every byte handed over, parsed or ignored.
  task automatic run_random(int unsigned target);
    int unsigned base;
    base = sent_bytes;
    while (sent_bytes - base < target) send_query();
  endtask

  initial begin
    logic [CfgW-1:0] limits[8];
    tracker = new();
    limits[0] = 13'd4096;
    limits[1] = 13'd1;
    limits[2] = 13'd2;
    limits[3] = 13'd16;
    limits[4] = MaxChunkReset;
    limits[5] = CfgW'($urandom_range(3, 300));
    limits[6] = CfgW'($urandom_range(1, 4096));
    limits[7] = 13'd0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    run_directed();

    for (int ph = 0; ph < 8; ph++) begin
      write_chunk_limit(limits[ph]);
      // Run one phase with both sides at full rate.
      no_idle = (ph == 3);
      run_random(65);
      no_idle = 1'b0;
    end

    settle();
    repeat (16) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
